### rtl/ground_point_sigma_filter_defines.svh
// assertion macros for the ground point filter checker
`ifndef GROUND_POINT_SIGMA_FILTER_DEFINES_SVH
`define GROUND_POINT_SIGMA_FILTER_DEFINES_SVH

// same-cycle implication, idle during reset
`define GPSF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle during reset
`define GPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define GPSF_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gpsf_pkg.sv
package gpsf_pkg;

   // coordinate and field widths
   localparam int COORD_W    = 24;
   localparam int RADIUS_W   = 48;
   localparam int SAMPLE_W   = 13;
   localparam int SQUARE_W   = 48;
   localparam int DEV_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // shared multiplier operand width and product width
   localparam int MUL_W  = 26;
   localparam int PROD_W = 2 * MUL_W;

   // half of a squared deviation fed to the multiplier per pass
   localparam int HALF_W = SQUARE_W / 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 48'd62500;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_HEIGHT    = 2'd1,
      OP_DEVIATION = 2'd2,
      OP_CLASSIFY  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DX,
      ST_MUL_DY,
      ST_RADIUS,
      ST_HEIGHT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SQUARE,
      ST_DEV_ACC,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/gpsf_mul.sv
module gpsf_mul (
   input  logic                                clock,
   input  logic signed [gpsf_pkg::MUL_W-1:0]  operand_a,
   input  logic signed [gpsf_pkg::MUL_W-1:0]  operand_b,
   output logic signed [gpsf_pkg::PROD_W-1:0] product_ff
);
   import gpsf_pkg::*;

   logic signed [PROD_W-1:0] product_in;

   // one signed product per cycle, registered
   assign product_in = operand_a * operand_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### rtl/gpsf_div.sv
module gpsf_div #(
   parameter int DIVIDEND_W = 37,
   parameter int DIVISOR_W  = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic        [DIVISOR_W-1:0]  divisor,
   output gpsf_pkg::div_status_type     status,
   output logic signed [DIVIDEND_W-1:0] quotient
);
   import gpsf_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         neg_in  = dividend[DIVIDEND_W-1];
         num_in  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign restore, truncation toward zero
   assign quotient    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### rtl/ground_point_sigma_filter.sv
// Two-sigma ground point filter. Stream the point cloud three times per frame: a clear
// beat (tuser 0), then every point as a height beat (1), a deviation beat (2) and a
// classify beat (3); set center_x, center_y and radius_sq while the block is idle. Each
// beat returns one result: tdata[0] inside the radius, tdata[1] kept as ground (classify
// only), tdata[14:2] the in-radius count. Items are taken one at a time and all multiplication
// runs through one registered 26x26 multiplier. Every beat but a clear squares dx and dy to
// test the radius; a height beat adds an in-radius point to the count and sum, a deviation
// beat adds dz squared to the deviation sum, and a classify beat keeps a point whose dz squared
// times the count is below four times that sum (both for an in-radius point of a non-empty set).
// The first deviation or classify beat after a clear also waits for the mean from a restoring
// divider, one bit per cycle; a result waits in an output register while the next beat is taken.
module ground_point_sigma_filter #(
   parameter int MAX_POINTS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: point_x [23:0], point_y [47:24], point_z [71:48]
   input  logic [71:0] req_tdata,
   // req_tuser: opcode [1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: inside_res [0], keep [1], sample_count [14:2], zero [15]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic                                csr_we,
   input  logic [gpsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gpsf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gpsf_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = COORD_W + CNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   state_type state_ff, state_in;

   // configuration
   logic signed [COORD_W-1:0] center_x_ff, center_x_in;
   logic signed [COORD_W-1:0] center_y_ff, center_y_in;
   logic [RADIUS_W-1:0]       radius_sq_ff, radius_sq_in;

   // latched beat
   opcode_type                op_ff, op_in;
   logic signed [COORD_W-1:0] px_ff, px_in;
   logic signed [COORD_W-1:0] py_ff, py_in;
   logic signed [COORD_W-1:0] pz_ff, pz_in;

   // per-beat work registers
   logic                inside_ff, inside_in;
   logic                keep_ff, keep_in;
   logic [SQUARE_W-1:0] acc_ff, acc_in;
   logic [SQUARE_W-1:0] s_ff, s_in;

   // frame state
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [COORD_W-1:0] mean_ff, mean_in;
   logic                      mean_ready_ff, mean_ready_in;
   logic [DEV_W-1:0]          dev_ff, dev_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic                     div_start;
   div_status_type           div_status;
   logic signed [SUM_W-1:0]  quotient;

   logic                          accept;
   logic                          out_free;
   logic signed [COORD_W:0]       dx, dy, dz;
   logic [MUL_W-1:0]              count_ext;
   logic [RADIUS_W:0]             dist_sq;
   logic [DEV_W+1:0]              scaled;
   logic [DEV_W:0]                dev_sum;
   logic [SAMPLE_W+CNT_W-1:0]     sample_ext;
   logic                          use_point;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign dx        = {px_ff[COORD_W-1], px_ff} - {center_x_ff[COORD_W-1], center_x_ff};
   assign dy        = {py_ff[COORD_W-1], py_ff} - {center_y_ff[COORD_W-1], center_y_ff};
   assign dz        = {pz_ff[COORD_W-1], pz_ff} - {mean_ff[COORD_W-1], mean_ff};
   assign count_ext = {{(MUL_W-CNT_W){1'b0}}, count_ff};
   assign use_point = inside_ff && (count_ff != '0);
   assign sample_ext = {{SAMPLE_W{1'b0}}, count_ff};

   gpsf_mul u_mul (
      .clock      (clock),
      .operand_a  (mul_a),
      .operand_b  (mul_b),
      .product_ff (product)
   );

   gpsf_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (opcode_type'(req_tuser) == OP_CLEAR) ? ST_DONE : ST_MUL_DX;
            end
         end
         ST_MUL_DX: state_in = ST_MUL_DY;
         ST_MUL_DY: state_in = ST_RADIUS;
         ST_RADIUS: begin
            if (op_ff == OP_HEIGHT) begin
               state_in = ST_HEIGHT;
            end else if (mean_ready_ff) begin
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_HEIGHT:    state_in = ST_DONE;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (!use_point) begin
               state_in = ST_DONE;
            end else if (op_ff == OP_DEVIATION) begin
               state_in = ST_DEV_ACC;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_DEV_ACC: state_in = ST_DONE;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, multiplier operands, divider start
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = !div_status.busy;
         ST_MUL_DX: begin
            mul_a = {dx[COORD_W], dx};
            mul_b = {dx[COORD_W], dx};
         end
         ST_MUL_DY: begin
            mul_a = {dy[COORD_W], dy};
            mul_b = {dy[COORD_W], dy};
         end
         ST_DIV_START: div_start = 1'b1;
         ST_SQUARE: begin
            mul_a = {dz[COORD_W], dz};
            mul_b = {dz[COORD_W], dz};
         end
         ST_MUL_LO: begin
            mul_a = {{(MUL_W-HALF_W){1'b0}}, product[HALF_W-1:0]};
            mul_b = count_ext;
         end
         ST_MUL_HI: begin
            mul_a = {{(MUL_W-HALF_W){1'b0}}, s_ff[SQUARE_W-1:HALF_W]};
            mul_b = count_ext;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // radius test, saturating deviation sum, classify compare
   assign dist_sq = {1'b0, acc_ff} + {1'b0, product[SQUARE_W-1:0]};
   assign dev_sum = {1'b0, dev_ff} + {{(DEV_W-SQUARE_W+1){1'b0}}, product[SQUARE_W-1:0]};
   assign scaled  = {product[DEV_W+1-HALF_W:0], {HALF_W{1'b0}}}
                  + {{(DEV_W+2-SQUARE_W){1'b0}}, acc_ff};

   // datapath next values
   always_comb begin
      center_x_in   = center_x_ff;
      center_y_in   = center_y_ff;
      radius_sq_in  = radius_sq_ff;
      op_in         = op_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      inside_in     = inside_ff;
      keep_in       = keep_ff;
      acc_in        = acc_ff;
      s_in          = s_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      mean_in       = mean_ff;
      mean_ready_in = mean_ready_ff;
      dev_in        = dev_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:  center_x_in  = csr_wdata[COORD_W-1:0];
            CSR_CENTER_Y:  center_y_in  = csr_wdata[COORD_W-1:0];
            CSR_RADIUS_SQ: radius_sq_in = csr_wdata[RADIUS_W-1:0];
            default:       center_x_in  = center_x_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = opcode_type'(req_tuser);
               px_in     = req_tdata[COORD_W-1:0];
               py_in     = req_tdata[2*COORD_W-1:COORD_W];
               pz_in     = req_tdata[3*COORD_W-1:2*COORD_W];
               inside_in = 1'b0;
               keep_in   = 1'b0;
               if (opcode_type'(req_tuser) == OP_CLEAR) begin
                  count_in      = '0;
                  sum_in        = '0;
                  mean_in       = '0;
                  mean_ready_in = 1'b0;
                  dev_in        = '0;
               end
            end
         end
         ST_MUL_DY: acc_in = product[SQUARE_W-1:0];
         ST_RADIUS: inside_in = dist_sq < {1'b0, radius_sq_ff};
         ST_HEIGHT: begin
            if (inside_ff && (count_ff < CNT_MAX)) begin
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + {{(SUM_W-COORD_W){pz_ff[COORD_W-1]}}, pz_ff};
            end
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               mean_in       = (count_ff == '0) ? '0 : quotient[COORD_W-1:0];
               mean_ready_in = 1'b1;
            end
         end
         ST_DEV_ACC: dev_in = dev_sum[DEV_W] ? {DEV_W{1'b1}} : dev_sum[DEV_W-1:0];
         ST_MUL_LO:  s_in = product[SQUARE_W-1:0];
         ST_MUL_HI:  acc_in = product[SQUARE_W-1:0];
         ST_COMPARE: keep_in = scaled < {dev_ff, 2'b00};
         default:    acc_in = acc_ff;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, sample_ext[SAMPLE_W-1:0], keep_ff, inside_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         radius_sq_ff  <= RADIUS_SQ_RESET;
         count_ff      <= '0;
         sum_ff        <= '0;
         mean_ff       <= '0;
         mean_ready_ff <= 1'b0;
         dev_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         center_x_ff   <= center_x_in;
         center_y_ff   <= center_y_in;
         radius_sq_ff  <= radius_sq_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         mean_ff       <= mean_in;
         mean_ready_ff <= mean_ready_in;
         dev_ff        <= dev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      inside_ff   <= inside_in;
      keep_ff     <= keep_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/gpsf_checker.sv
`include "ground_point_sigma_filter_defines.svh"

module gpsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // a stalled result beat holds
   `GPSF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")

   // a ground point always lies inside the radius
   `GPSF_ASSERT_NOW(a_keep_inside, rsp_tvalid && rsp_tdata[1], rsp_tdata[0], "kept point outside the radius")

   // one point at a time: ready drops after each accepted beat
   `GPSF_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "beat accepted while busy")

   // reset leaves the block idle with no result pending
   `GPSF_ASSERT_NEXT_RAW(a_reset_idle, reset, req_tready && !rsp_tvalid, "block not idle after reset")

endmodule

bind ground_point_sigma_filter gpsf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
